FILE: hdl/mbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_pkg
// Types and constants shared by the masked byte signature matcher and its
// port checker.
// ----------------------------------------------------------------------------
package mbsm_pkg;

	localparam int DATA_W     = 8;
	localparam int LEN_W      = 6;
	localparam int SEL_W      = 2;
	localparam int POS_W      = 5;
	localparam int NUM_REGS   = 4;
	localparam int IDX_W      = 2;
	localparam int CNT_W      = 6;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;
	localparam int RES_W      = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// tuser bit positions on the input side
	localparam int USER_MODE  = 0;
	localparam int USER_FIRST = 1;

	typedef enum logic [0:0] {
		MODE_SCAN = 1'b0,
		MODE_LOAD = 1'b1
	} mode_t;

	// input tdata, lowest field in the lowest bits
	typedef struct packed {
		logic             care;
		logic [POS_W-1:0] byte_pos;
		logic [SEL_W-1:0] pattern_sel;
		logic [DATA_W-1:0] data_byte;
	} in_data_t;

	// result fields, lowest field in the lowest bits
	typedef struct packed {
		logic             region_match;
		logic [SEL_W-1:0] match_pattern;
		logic             match_now;
	} res_t;

endpackage

FILE: hdl/masked_byte_signature_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_matcher
// Scans a byte stream for up to NUM_SIGNATURES masked signatures and flags
// where one ends, which one, and whether the current region has hit.
// ----------------------------------------------------------------------------
// One item per clock unless the downstream side stalls. An item enters the
// input stage on accept; the window and region count (scan items) or the
// signature table (load items) update at that edge, and its result is then
// registered in the result register, from which it is offered downstream.
// Every stored signature byte is compared against its window byte in
// parallel between the input stage and the result register. An output
// register holds a result while the downstream side stalls, and a new item
// is still taken whenever the input stage is empty or that register is
// empty or being drained. Signature bytes are loaded with mode 1 items;
// lengths come from the configuration port, zero disables a signature.
module masked_byte_signature_matcher #(
	parameter int NUM_SIGNATURES = 4,
	parameter int MAX_SIG_LEN    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data_byte[7:0], pattern_sel[9:8], byte_pos[14:10], care[15]
	input  logic [mbsm_pkg::IN_DATA_W-1:0]    s_tdata,
	// mode[0], region_first[1]
	input  logic [mbsm_pkg::IN_USER_W-1:0]    s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// match_now[0], match_pattern[2:1], region_match[3], zero[7:4]
	output logic [mbsm_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [mbsm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [mbsm_pkg::LEN_W-1:0]        cfg_data
);

	localparam int WIN_AW    = $clog2(MAX_SIG_LEN);
	localparam int TAB_DEPTH = NUM_SIGNATURES * MAX_SIG_LEN;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);

	mbsm_pkg::in_data_t                 in_d;
	mbsm_pkg::mode_t                    in_mode;
	logic                               acc;
	logic                               scan_acc;
	logic                               tab_we;
	logic [TAB_AW-1:0]                  tab_addr;

	logic [mbsm_pkg::LEN_W-1:0]         length_q [mbsm_pkg::NUM_REGS];
	logic [mbsm_pkg::DATA_W-1:0]        window_q [MAX_SIG_LEN];
	logic [mbsm_pkg::DATA_W-1:0]        pat_q    [TAB_DEPTH];
	logic [TAB_DEPTH-1:0]               care_q;
	logic [mbsm_pkg::CNT_W-1:0]         cnt_q;
	logic [mbsm_pkg::CNT_W-1:0]         cnt_base;
	logic                               region_hit_q;

	logic                               valid_s1;
	mbsm_pkg::mode_t                    mode_s1;
	logic                               first_s1;
	logic                               last_s1;

	logic                               adv;
	logic [NUM_SIGNATURES-1:0]          sig_ok;
	logic                               hit;
	logic [mbsm_pkg::SEL_W-1:0]         which;
	logic                               region_next;

	logic                               out_valid_q;
	mbsm_pkg::res_t                     res_q;
	logic                               out_last_q;

	assign in_d     = mbsm_pkg::in_data_t'(s_tdata);
	assign in_mode  = mbsm_pkg::mode_t'(s_tuser[mbsm_pkg::USER_MODE]);
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;
	assign scan_acc = acc && (in_mode == mbsm_pkg::MODE_SCAN);
	assign tab_we   = acc && (in_mode == mbsm_pkg::MODE_LOAD)
		&& ({1'b0, in_d.pattern_sel} < 3'(NUM_SIGNATURES))
		&& ({2'b0, in_d.byte_pos} < 7'(MAX_SIG_LEN));
	assign tab_addr = TAB_AW'(in_d.pattern_sel * MAX_SIG_LEN + in_d.byte_pos);
	assign cnt_base = s_tuser[mbsm_pkg::USER_FIRST] ? '0 : cnt_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < mbsm_pkg::NUM_REGS; r++) begin
				length_q[r] <= '0;
			end
		end else if (cfg_we) begin
			length_q[cfg_index] <= cfg_data;
		end
	end

	// byte window, newest byte in entry 0
	always_ff @(posedge clk) begin
		if (scan_acc) begin
			window_q[0] <= in_d.data_byte;
			for (int i = 1; i < MAX_SIG_LEN; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	// signature table
	always_ff @(posedge clk) begin
		for (int e = 0; e < TAB_DEPTH; e++) begin
			if (tab_we && tab_addr == TAB_AW'(e)) begin
				pat_q[e] <= in_d.data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q <= '0;
		end else begin
			for (int e = 0; e < TAB_DEPTH; e++) begin
				if (tab_we && tab_addr == TAB_AW'(e)) begin
					care_q[e] <= in_d.care;
				end
			end
		end
	end

	// region byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (scan_acc) begin
			cnt_q <= (cnt_base == mbsm_pkg::CNT_MAX) ? cnt_base : cnt_base + 1'b1;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1  <= in_mode;
			first_s1 <= s_tuser[mbsm_pkg::USER_FIRST];
			last_s1  <= s_tlast;
		end
	end

	// masked compare of every signature against the window
	for (genvar g = 0; g < NUM_SIGNATURES; g++) begin : g_sig
		logic [MAX_SIG_LEN-1:0]       mism;
		logic [mbsm_pkg::LEN_W:0]     len;

		assign len = {1'b0, length_q[g]};

		always_comb begin
			logic [6:0] idx_full;
			for (int j = 0; j < MAX_SIG_LEN; j++) begin
				idx_full = 7'(len) - 7'(j) - 7'd1;
				mism[j]  = (7'(j) < 7'(len)) && care_q[g*MAX_SIG_LEN + j]
					&& (pat_q[g*MAX_SIG_LEN + j] != window_q[idx_full[WIN_AW-1:0]]);
			end
		end

		assign sig_ok[g] = (len != '0) && (7'(len) <= 7'(MAX_SIG_LEN))
			&& ({1'b0, cnt_q} >= len) && (mism == '0);
	end

	always_comb begin
		hit   = 1'b0;
		which = '0;
		for (int s = NUM_SIGNATURES - 1; s >= 0; s--) begin
			if (sig_ok[s]) begin
				hit   = 1'b1;
				which = mbsm_pkg::SEL_W'(s);
			end
		end
	end

	assign region_next = (first_s1 ? 1'b0 : region_hit_q) | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_hit_q <= 1'b0;
		end else if (adv && valid_s1 && mode_s1 == mbsm_pkg::MODE_SCAN) begin
			region_hit_q <= region_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			if (mode_s1 == mbsm_pkg::MODE_LOAD) begin
				res_q      <= '0;
				out_last_q <= 1'b0;
			end else begin
				res_q.match_now     <= hit;
				res_q.match_pattern <= which;
				res_q.region_match  <= region_next;
				out_last_q          <= last_s1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(mbsm_pkg::OUT_DATA_W - mbsm_pkg::RES_W)'(0), res_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: hdl/mbsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_checker
// Port-level checks for the masked byte signature matcher, bound to the
// top level.
// ----------------------------------------------------------------------------
module mbsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mbsm_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted item produced no result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_match_sets_region: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[3])
		else $error("match without region hit");

	a_no_match_zero_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'b00)
		else $error("signature index without match");

endmodule

bind masked_byte_signature_matcher mbsm_checker u_mbsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
